### design/ofp_pkg.sv
// shared types and constants for the optical flow frame parser
`default_nettype none
package ofp_pkg;

  localparam logic [7:0] FRAME_HEADER = 8'hFE;

  localparam int unsigned POS_W = 4;

  localparam logic [POS_W-1:0] POS_FIRST = 4'd1;
  localparam logic [POS_W-1:0] POS_X_LO  = 4'd2;
  localparam logic [POS_W-1:0] POS_X_HI  = 4'd3;
  localparam logic [POS_W-1:0] POS_Y_LO  = 4'd4;
  localparam logic [POS_W-1:0] POS_Y_HI  = 4'd5;
  localparam logic [POS_W-1:0] POS_CHECK = 4'd6;
  localparam logic [POS_W-1:0] POS_LAST  = 4'd8;

  // frame tracker state seen by the top level flow control
  typedef struct packed {
    logic at_last;
  } ofp_status_t;

  // one decoded frame handed to the accumulator
  typedef struct packed {
    logic               emit;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } ofp_frame_t;

endpackage
`default_nettype wire

### design/ofp_if.sv
// handshake channels for received bytes and decoded displacements
`default_nettype none
interface ofp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ofp_flow_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic signed [31:0] total_x;
  logic signed [31:0] total_y;

  modport source (output valid, output delta_x, output delta_y,
                  output total_x, output total_y, input ready);
  modport sink (input valid, input delta_x, input delta_y,
                input total_x, input total_y, output ready);
endinterface
`default_nettype wire

### design/ofp_frame.sv
// header hunt, byte position tracking, payload capture and checksum
`default_nettype none
module ofp_frame (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [7:0]        rx_byte,
  output ofp_pkg::ofp_status_t   status,
  output ofp_pkg::ofp_frame_t    frame
);
  import ofp_pkg::*;

  logic             header_seen;
  logic [POS_W-1:0] byte_position;
  logic [7:0]       x_lo;
  logic [7:0]       x_hi;
  logic [7:0]       y_lo;
  logic [7:0]       y_hi;
  logic             check_good;
  logic [7:0]       chk;

  assign chk = x_lo + x_hi + y_lo + y_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_seen   <= 1'b0;
      byte_position <= POS_FIRST;
      check_good    <= 1'b0;
    end else if (fire) begin
      if (!header_seen) begin
        if (rx_byte == FRAME_HEADER) begin
          header_seen   <= 1'b1;
          byte_position <= POS_FIRST;
        end
      end else if (byte_position >= POS_LAST) begin
        header_seen   <= 1'b0;
        byte_position <= POS_FIRST;
      end else begin
        byte_position <= byte_position + POS_W'(1);
        if (byte_position == POS_CHECK) begin
          check_good <= (chk == rx_byte);
        end
      end
    end
  end

  // payload bytes need no reset, each is written before the checksum reads it
  always_ff @(posedge clk) begin
    if (fire && header_seen) begin
      case (byte_position)
        POS_X_LO: x_lo <= rx_byte;
        POS_X_HI: x_hi <= rx_byte;
        POS_Y_LO: y_lo <= rx_byte;
        POS_Y_HI: y_hi <= rx_byte;
        default: ;
      endcase
    end
  end

  assign status.at_last = header_seen && (byte_position >= POS_LAST);

  assign frame.emit = fire && status.at_last && check_good;
  assign frame.dx   = {x_hi, x_lo};
  assign frame.dy   = {y_hi, y_lo};
endmodule
`default_nettype wire

### design/ofp_accum.sv
// running sums and the result register
`default_nettype none
module ofp_accum (
  input  wire logic                clk,
  input  wire logic                rst,
  input  ofp_pkg::ofp_frame_t      frame,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic signed [15:0]       delta_x,
  output logic signed [15:0]       delta_y,
  output logic signed [31:0]       total_x,
  output logic signed [31:0]       total_y
);
  import ofp_pkg::*;

  logic signed [31:0] sum_x;
  logic signed [31:0] sum_y;
  logic signed [31:0] sum_x_next;
  logic signed [31:0] sum_y_next;

  assign sum_x_next = sum_x + {{16{frame.dx[15]}}, frame.dx};
  assign sum_y_next = sum_y + {{16{frame.dy[15]}}, frame.dy};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x     <= '0;
      sum_y     <= '0;
      out_valid <= 1'b0;
    end else if (frame.emit) begin
      sum_x     <= sum_x_next;
      sum_y     <= sum_y_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.emit) begin
      delta_x <= frame.dx;
      delta_y <= frame.dy;
      total_x <= sum_x_next;
      total_y <= sum_y_next;
    end
  end
endmodule
`default_nettype wire

### design/optical_flow_frame_parser_unit.sv
// optical flow frame parser top level
// Usage:
//   byte_in carries one received link byte per request. While idle the
//   block drops bytes until the header 0xFE, then takes eight more bytes.
//   Bytes 2..5 are X low, X high, Y low, Y high; byte 6 is their 8-bit sum.
//   flow_out gives one request per frame with a good checksum: the signed
//   X and Y displacements and the wrapped 32-bit running sums after them.
//   A frame with a bad checksum gives nothing and leaves the sums alone.
//   Throughput is one byte per cycle, set by the position counter and
//   payload registers. A result shows on flow_out in the cycle
//   after the last byte of its frame is accepted, from the result register.
//   A waiting result does not block input: bytes keep flowing while it
//   waits; only the last byte of the next frame is held off until the
//   result has been taken. At synchronous reset the parser hunts for a
//   header, the sums clear to zero and no result is pending.
`default_nettype none
module optical_flow_frame_parser_unit (
  input wire logic  clk,
  input wire logic  rst,
  ofp_byte_if.sink  byte_in,
  ofp_flow_if.source flow_out
);
  import ofp_pkg::*;

  ofp_status_t status;
  ofp_frame_t  frame;
  logic        fire;

  // only the closing byte of a frame can produce a result
  assign byte_in.ready = !(status.at_last && flow_out.valid && !flow_out.ready);
  assign fire          = byte_in.valid && byte_in.ready;

  ofp_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (byte_in.rx_byte),
    .status  (status),
    .frame   (frame)
  );

  ofp_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .out_ready (flow_out.ready),
    .out_valid (flow_out.valid),
    .delta_x   (flow_out.delta_x),
    .delta_y   (flow_out.delta_y),
    .total_x   (flow_out.total_x),
    .total_y   (flow_out.total_y)
  );
endmodule
`default_nettype wire

### test/ofp_flow_checker.sv
// frame tracker and result checker for the optical flow frame parser
module ofp_flow_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  logic               byte_ready,
  input  logic [7:0]         rx_byte,
  input  logic               flow_valid,
  input  logic               flow_ready,
  input  logic signed [15:0] delta_x,
  input  logic signed [15:0] delta_y,
  input  logic signed [31:0] total_x,
  input  logic signed [31:0] total_y,
  output int                 mismatches,
  output int                 pending
);
  import ofp_pkg::*;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } flow_result_t;

  flow_result_t       expected_flow[$];
  logic               in_frame;
  logic [POS_W-1:0]   frame_pos;
  logic [7:0]         payload[4];
  logic               sum_ok;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;

  task automatic track_byte(input logic [7:0] b);
    logic [7:0]         chk;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    flow_result_t       r;
    if (!in_frame) begin
      if (b == FRAME_HEADER) begin
        in_frame = 1'b1;
        frame_pos = POS_FIRST;
      end
      return;
    end
    // a header byte inside a frame is plain payload
    if (frame_pos >= POS_X_LO && frame_pos <= POS_Y_HI) begin
      payload[2'(frame_pos - POS_X_LO)] = b;
    end else if (frame_pos == POS_CHECK) begin
      chk = payload[0] + payload[1] + payload[2] + payload[3];
      sum_ok = (chk == b);
    end
    if (frame_pos < POS_LAST) begin
      frame_pos = frame_pos + POS_W'(1);
    end else begin
      in_frame = 1'b0;
      frame_pos = POS_FIRST;
      if (sum_ok) begin
        dx = {payload[1], payload[0]};
        dy = {payload[3], payload[2]};
        acc_x = acc_x + {{16{dx[15]}}, dx};
        acc_y = acc_y + {{16{dy[15]}}, dy};
        r.dx = dx;
        r.dy = dy;
        r.tx = acc_x;
        r.ty = acc_y;
        expected_flow.push_back(r);
      end
    end
  endtask

  task automatic check_flow();
    flow_result_t want;
    if (expected_flow.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected flow request: dx=%0d dy=%0d tx=%0d ty=%0d",
                 delta_x, delta_y, total_x, total_y);
      return;
    end
    want = expected_flow.pop_front();
    if (want.dx !== delta_x || want.dy !== delta_y ||
        want.tx !== total_x || want.ty !== total_y) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"flow mismatch: expected dx=%0d dy=%0d tx=%0d ty=%0d, ",
                  "got dx=%0d dy=%0d tx=%0d ty=%0d"},
                 want.dx, want.dy, want.tx, want.ty,
                 delta_x, delta_y, total_x, total_y);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_frame = 1'b0;
      frame_pos = POS_FIRST;
      sum_ok = 1'b0;
      acc_x = '0;
      acc_y = '0;
      expected_flow.delete();
      mismatches = 0;
    end else begin
      // a result never comes from the byte taken at the same edge
      if (flow_valid && flow_ready) check_flow();
      if (byte_valid && byte_ready) track_byte(rx_byte);
    end
    pending = expected_flow.size();
  end

endmodule

### test/tb_optical_flow_frame_parser_unit.sv
// stimulus and verdict for the optical flow frame parser
module tb_optical_flow_frame_parser_unit;
  import ofp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 550;
  localparam int HOLD_CYCLES    = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ofp_byte_if byte_ch();
  ofp_flow_if flow_ch();

  int mismatches;
  int pending;
  int idle_cycles = 0;
  int sent_items = 0;
  int send_mode = 0;
  int recv_mode = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  optical_flow_frame_parser_unit uut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_ch),
    .flow_out (flow_ch)
  );

  ofp_flow_checker flow_chk (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_ch.valid),
    .byte_ready (byte_ch.ready),
    .rx_byte    (byte_ch.rx_byte),
    .flow_valid (flow_ch.valid),
    .flow_ready (flow_ch.ready),
    .delta_x    (flow_ch.delta_x),
    .delta_y    (flow_ch.delta_y),
    .total_x    (flow_ch.total_x),
    .total_y    (flow_ch.total_y),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the request
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      byte_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid = 1'b1;
    byte_ch.rx_byte = b;
    do @(posedge clk); while (!byte_ch.ready);
    @(negedge clk);
    sent_items++;
    if ($urandom_range(0, 31) == 0) send_mode = $urandom_range(0, 2);
  endtask

  task automatic send_frame(input logic [15:0] dx, input logic [15:0] dy,
                            input logic [7:0] filler, input bit good);
    logic [7:0] chk;
    chk = dx[7:0] + dx[15:8] + dy[7:0] + dy[15:8];
    if (!good) chk = chk + 8'($urandom_range(1, 255));
    send_byte(FRAME_HEADER);
    send_byte(filler);
    send_byte(dx[7:0]);
    send_byte(dx[15:8]);
    send_byte(dy[7:0]);
    send_byte(dy[15:8]);
    send_byte(chk);
    send_byte(filler);
    send_byte(~filler);
  endtask

  // result side
  initial begin
    int gap;
    flow_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        // long hold-off so the parser fills up and stalls its input
        flow_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      gap = draw_gap(recv_mode);
      if (gap > 0) begin
        flow_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      flow_ch.ready = 1'b1;
      do @(posedge clk); while (!flow_ch.valid);
      @(negedge clk);
      if ($urandom_range(0, 15) == 0) recv_mode = $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (flow_ch.valid && flow_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int kind;
    int target;
    byte_ch.valid = 1'b0;
    byte_ch.rx_byte = 8'h00;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // noise while hunting, then extremes with header bytes as frame filler
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(16'h8000, 16'h7FFF, FRAME_HEADER, 1'b1);
    send_frame(16'hFFFF, 16'h0000, 8'h00, 1'b0);

    hold_req = 1'b1;
    target = sent_items + RANDOM_ITEMS;
    while (sent_items < target) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        // noise while hunting, not counted
        repeat ($urandom_range(1, 3)) begin
          send_byte(8'($urandom));
          sent_items--;
        end
      end else if (kind < 4) begin
        send_byte(FRAME_HEADER);
        repeat (8) send_byte(8'($urandom));
      end else begin
        send_frame(pick_word(), pick_word(), 8'($urandom), kind > 6);
      end
    end
    byte_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
